@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property checked at every rising edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");

// a condition that must never hold out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition: %m");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/sevec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_pkg
// Types, limits and helper functions of the shared exponent vector encoder.
// ----------------------------------------------------------------------------
package sevec_pkg;

  // packing modes
  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_HALF = 2'd1,
    MODE_SE32 = 2'd2,
    MODE_SE24 = 2'd3
  } mode_e;

  // classification limits on the raw bit pattern
  localparam logic [31:0] LIM_WRONG = 32'h7F80_0000;
  localparam logic [31:0] LIM_BIG   = 32'h4000_0000;
  localparam logic [31:0] LIM_SMALL = 32'h3080_0000;

  // low five bits of the saturated shared exponents (0x7F and 0x60)
  localparam logic [4:0] EXP_SAT_HI = 5'h1F;
  localparam logic [4:0] EXP_SAT_LO = 5'h00;

  // bytes per mode
  localparam logic [3:0] BYTES_RAW  = 4'd12;
  localparam logic [3:0] BYTES_HALF = 4'd6;
  localparam logic [3:0] BYTES_SE32 = 4'd4;
  localparam logic [3:0] BYTES_SE24 = 4'd3;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } vec_t;

  // after classify stage
  typedef struct packed {
    vec_t       v;
    mode_e      mode;
    logic       wrong;
    logic [2:0] big;    // [0] a, [1] b, [2] c
    logic [2:0] tiny;
    logic       gt_ab;
    logic       gt_ac;
    logic       gt_bc;
  } s1_t;

  // after exponent stage
  typedef struct packed {
    vec_t        v;
    mode_e       mode;
    logic        wrong;
    logic [2:0]  big;
    logic [4:0]  shared;
    logic [15:0] h0;
    logic [15:0] h1;
    logic [15:0] h2;
  } s2_t;

  // one result beat
  typedef struct packed {
    logic [31:0] word_low;
    logic [31:0] word_mid;
    logic [31:0] word_high;
    logic        write_valid;
    logic [3:0]  byte_count;
  } res_t;

  // 16-bit truncated field
  function automatic logic [15:0] half_field(logic [31:0] p, logic big, logic tiny);
    logic [15:0] r;
    if (big) begin
      r = 16'hFFFF;
    end else if (tiny) begin
      r = 16'h0000;
    end else begin
      r = p[27:12];
    end
    return r;
  endfunction

  // mantissa with hidden bit aligned to the shared exponent, shift wraps mod 32
  function automatic logic [23:0] align_mant(logic [31:0] p, logic big, logic [4:0] shared);
    logic [4:0] sh;
    logic [23:0] m;
    sh = 5'd1 + shared - p[27:23];
    m  = {1'b1, p[22:0]} >> sh;
    return big ? 24'hFF_FFFF : m;
  endfunction

endpackage

@@ rtl/sevec_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_in_if
// Input channel: three single-precision bit patterns per beat.
// ----------------------------------------------------------------------------
interface sevec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] comp_a;
  logic [31:0] comp_b;
  logic [31:0] comp_c;

  modport source (output valid, output comp_a, output comp_b, output comp_c, input ready);
  modport sink (input valid, input comp_a, input comp_b, input comp_c, output ready);
endinterface

@@ rtl/sevec_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_out_if
// Output channel: packed words, write flag and byte count per beat.
// ----------------------------------------------------------------------------
interface sevec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_low;
  logic [31:0] word_mid;
  logic [31:0] word_high;
  logic        write_valid;
  logic [3:0]  byte_count;

  modport source (output valid, output word_low, output word_mid, output word_high,
                  output write_valid, output byte_count, input ready);
  modport sink (input valid, input word_low, input word_mid, input word_high,
                input write_valid, input byte_count, output ready);
endinterface

@@ rtl/sevec_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_cfg_if
// Configuration write channel for the pack mode register.
// ----------------------------------------------------------------------------
interface sevec_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] pack_mode;

  modport source (output valid, output pack_mode, input ready);
  modport sink (input valid, input pack_mode, output ready);
endinterface

@@ rtl/shared_exponent_vector_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_exponent_vector_encoder_top
// Packs three single-precision components as raw, 16-bit or shared
// exponent words; three register stages with per-stage valid.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                        Beat
// cfg_i    in   pack_mode[1:0]                                 valid & ready
// in_i     in   comp_a, comp_b, comp_c [31:0]                  valid & ready
// out_o    out  word_low/mid/high[31:0], write_valid, count[3:0]  valid & ready
//
// One beat per cycle sustained while out_o is ready; one register stage
// each (classify, shared exponent, align and pack).
// Reset clears all stage valid bits and sets pack_mode to raw.
// Each stage holds while its successor is full and not draining, so empty
// stages keep taking beats while a finished result waits at the output.
// cfg_i is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shared_exponent_vector_encoder_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  sevec_cfg_if.sink   cfg_i,
  sevec_in_if.sink    in_i,
  sevec_out_if.source out_o
);
  import sevec_pkg::*;

  mode_e pack_mode_q;
  vec_t  vec_in;
  logic  s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t   s1_data;
  s2_t   s2_data;
  res_t  res;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_mode_q <= MODE_RAW;
    end else if (cfg_i.valid) begin
      pack_mode_q <= mode_e'(cfg_i.pack_mode);
    end
  end

  assign vec_in.a = in_i.comp_a;
  assign vec_in.b = in_i.comp_b;
  assign vec_in.c = in_i.comp_c;

  // pipeline
  sevec_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .vec_i   (vec_in),
    .mode_i  (pack_mode_q),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  sevec_exponent u_exponent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  sevec_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.word_low    = res.word_low;
  assign out_o.word_mid    = res.word_mid;
  assign out_o.word_high   = res.word_high;
  assign out_o.write_valid = res.write_valid;
  assign out_o.byte_count  = res.byte_count;

  // checks
  `ASSERT_PROP(a_drop_zero, clk_i, rst_ni, (out_o.valid && !out_o.write_valid) |-> (out_o.word_low == 32'd0 && out_o.word_mid == 32'd0 && out_o.word_high == 32'd0))
  `ASSERT_PROP(a_drop_half, clk_i, rst_ni, (out_o.valid && !out_o.write_valid) |-> (out_o.byte_count == BYTES_HALF))
  `ASSERT_PROP(a_se_unused, clk_i, rst_ni, (out_o.valid && (out_o.byte_count == BYTES_SE32 || out_o.byte_count == BYTES_SE24)) |-> (out_o.word_mid == 32'd0 && out_o.word_high == 32'd0))
  `ASSERT_NEVER(a_se24_top, clk_i, rst_ni, out_o.valid && out_o.byte_count == BYTES_SE24 && out_o.word_low[31:23] != 9'd0)
  `ASSERT_PROP(a_stall_hold, clk_i, rst_ni, (s2_valid && !s2_ready) |=> s2_valid)
endmodule

@@ rtl/sevec_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_classify
// Stage 1: classify each component and compare them pairwise.
// ----------------------------------------------------------------------------
module sevec_classify (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sevec_pkg::vec_t   vec_i,
  input  sevec_pkg::mode_e  mode_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sevec_pkg::s1_t    data_o
);
  import sevec_pkg::*;

  logic valid_q, valid_d;
  s1_t  data_q, data_d;
  logic load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  // classification and comparisons
  always_comb begin
    data_d.v        = vec_i;
    data_d.mode     = mode_i;
    data_d.wrong    = (vec_i.a >= LIM_WRONG) || (vec_i.b >= LIM_WRONG) ||
                      (vec_i.c >= LIM_WRONG);
    data_d.big[0]   = vec_i.a >= LIM_BIG;
    data_d.big[1]   = vec_i.b >= LIM_BIG;
    data_d.big[2]   = vec_i.c >= LIM_BIG;
    data_d.tiny[0]  = vec_i.a < LIM_SMALL;
    data_d.tiny[1]  = vec_i.b < LIM_SMALL;
    data_d.tiny[2]  = vec_i.c < LIM_SMALL;
    data_d.gt_ab    = vec_i.a > vec_i.b;
    data_d.gt_ac    = vec_i.a > vec_i.c;
    data_d.gt_bc    = vec_i.b > vec_i.c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ rtl/sevec_exponent.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_exponent
// Stage 2: pick the largest component, derive the shared exponent and the
// 16-bit truncated fields.
// ----------------------------------------------------------------------------
module sevec_exponent (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sevec_pkg::s1_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output sevec_pkg::s2_t  data_o
);
  import sevec_pkg::*;

  logic       valid_q, valid_d;
  s2_t        data_q, data_d;
  logic       load;
  logic [1:0] max_sel;   // 0 a, 1 b, 2 c
  logic [31:0] mx;
  logic       mx_big, mx_tiny;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  // largest component from the stage-1 comparisons
  always_comb begin
    if (data_i.gt_ab) begin
      max_sel = data_i.gt_ac ? 2'd0 : 2'd2;
    end else begin
      max_sel = data_i.gt_bc ? 2'd1 : 2'd2;
    end
    case (max_sel)
      2'd0: begin
        mx = data_i.v.a; mx_big = data_i.big[0]; mx_tiny = data_i.tiny[0];
      end
      2'd1: begin
        mx = data_i.v.b; mx_big = data_i.big[1]; mx_tiny = data_i.tiny[1];
      end
      default: begin
        mx = data_i.v.c; mx_big = data_i.big[2]; mx_tiny = data_i.tiny[2];
      end
    endcase
  end

  // shared exponent and half fields
  always_comb begin
    data_d.v     = data_i.v;
    data_d.mode  = data_i.mode;
    data_d.wrong = data_i.wrong;
    data_d.big   = data_i.big;
    if (data_i.wrong) begin
      data_d.shared = 5'd0;
    end else if (mx_big) begin
      data_d.shared = EXP_SAT_HI;
    end else if (mx_tiny) begin
      data_d.shared = EXP_SAT_LO;
    end else begin
      data_d.shared = mx[27:23];
    end
    data_d.h0 = half_field(data_i.v.a, data_i.big[0], data_i.tiny[0]);
    data_d.h1 = half_field(data_i.v.b, data_i.big[1], data_i.tiny[1]);
    data_d.h2 = half_field(data_i.v.c, data_i.big[2], data_i.tiny[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ rtl/sevec_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_pack
// Stage 3: align mantissas, pack the words for the mode; holds the output
// register.
// ----------------------------------------------------------------------------
module sevec_pack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sevec_pkg::s2_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sevec_pkg::res_t  data_o
);
  import sevec_pkg::*;

  logic        valid_q, valid_d;
  res_t        data_q, data_d;
  logic        load;
  logic [23:0] m1, m2, m3;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  // aligned mantissas, zero for an invalid vector
  always_comb begin
    m1 = align_mant(data_i.v.a, data_i.big[0], data_i.shared);
    m2 = align_mant(data_i.v.b, data_i.big[1], data_i.shared);
    m3 = align_mant(data_i.v.c, data_i.big[2], data_i.shared);
    if (data_i.wrong) begin
      m1 = 24'd0;
      m2 = 24'd0;
      m3 = 24'd0;
    end
  end

  // word packing per mode
  always_comb begin
    data_d.word_low    = 32'd0;
    data_d.word_mid    = 32'd0;
    data_d.word_high   = 32'd0;
    data_d.write_valid = 1'b1;
    data_d.byte_count  = BYTES_RAW;
    case (data_i.mode)
      MODE_RAW: begin
        data_d.word_low  = data_i.v.a;
        data_d.word_mid  = data_i.v.b;
        data_d.word_high = data_i.v.c;
      end
      MODE_HALF: begin
        data_d.byte_count = BYTES_HALF;
        if (data_i.wrong) begin
          data_d.write_valid = 1'b0;
        end else begin
          data_d.word_low = {data_i.h1, data_i.h0};
          data_d.word_mid = {16'd0, data_i.h2};
        end
      end
      MODE_SE32: begin
        data_d.byte_count = BYTES_SE32;
        data_d.word_low   = {data_i.shared, m3[22:14], m2[22:14], m1[22:14]};
      end
      MODE_SE24: begin
        data_d.byte_count = BYTES_SE24;
        data_d.word_low   = {9'd0, data_i.shared[4:0], m3[22:17], m2[22:17],
                             m1[22:17]};
      end
      default: begin
        data_d.byte_count = BYTES_RAW;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ verif/sevec_pack_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sevec_pack_checker
// Watches the mode, vector and packed-word channels of the encoder. For each
// accepted vector it predicts the packed beat under the current pack mode and
// queues it. Each returned beat is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module sevec_pack_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sevec_cfg_if        cfg_i,
  sevec_in_if         in_i,
  sevec_out_if        out_i,
  output int unsigned mismatch_count_o
);
  import sevec_pkg::*;

  // full 8-bit shared exponents on saturation
  localparam logic [7:0] SHARED_TOP    = 8'h7F;
  localparam logic [7:0] SHARED_BOTTOM = 8'h60;
  localparam int unsigned MAX_PRINTED  = 40;

  mode_e       mode_q;
  res_t        packed_q[$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;

  // 16-bit truncated field: saturate when too big, zero when too small
  function automatic logic [15:0] trunc16(logic [31:0] p);
    if (p >= LIM_BIG) return 16'hFFFF;
    if (p < LIM_SMALL) return 16'h0000;
    return p[27:12];
  endfunction

  // mantissa with hidden bit, shifted down to the shared exponent (mod 32)
  function automatic logic [31:0] mant_at(logic [31:0] p, logic [7:0] shared);
    logic [31:0] shift_amt;
    if (p >= LIM_BIG) return 32'hFFFF_FFFF;
    shift_amt = 32'd1 + {24'd0, shared} - {24'd0, p[30:23]};
    return {8'd0, 1'b1, p[22:0]} >> shift_amt[4:0];
  endfunction

  // expected packed beat for one vector
  function automatic res_t pack_vector(mode_e mode, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] c);
    res_t        r;
    logic        invalid;
    logic [31:0] largest;
    logic [7:0]  shared;
    logic [31:0] ma, mb, mc;
    r           = '0;
    r.write_valid = 1'b1;
    invalid     = (a >= LIM_WRONG) || (b >= LIM_WRONG) || (c >= LIM_WRONG);
    shared      = 8'd0;
    ma          = '0;
    mb          = '0;
    mc          = '0;
    if (!invalid) begin
      largest = (a > b) ? a : b;
      largest = (largest > c) ? largest : c;
      if (largest >= LIM_BIG) begin
        shared = SHARED_TOP;
      end else if (largest < LIM_SMALL) begin
        shared = SHARED_BOTTOM;
      end else begin
        shared = largest[30:23];
      end
      ma = mant_at(a, shared);
      mb = mant_at(b, shared);
      mc = mant_at(c, shared);
    end
    case (mode)
      MODE_RAW: begin
        r.word_low   = a;
        r.word_mid   = b;
        r.word_high  = c;
        r.byte_count = BYTES_RAW;
      end
      MODE_HALF: begin
        r.byte_count = BYTES_HALF;
        // any invalid component drops the write and clears the words
        if (invalid) begin
          r.write_valid = 1'b0;
        end else begin
          r.word_low = {trunc16(b), trunc16(a)};
          r.word_mid = {16'd0, trunc16(c)};
        end
      end
      MODE_SE32: begin
        r.byte_count = BYTES_SE32;
        r.word_low   = {shared[4:0], mc[22:14], mb[22:14], ma[22:14]};
      end
      MODE_SE24: begin
        r.byte_count = BYTES_SE24;
        r.word_low   = {9'd0, shared[4:0], mc[22:17], mb[22:17], ma[22:17]};
      end
      default: begin
        r.byte_count = BYTES_RAW;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: packed beat mismatch:%s", $time, msg);
    end
    mismatches++;
  endtask

  // compare one returned beat with the oldest prediction
  task automatic check_beat(res_t got);
    res_t  want;
    string diffs;
    diffs = "";
    if (packed_q.size() == 0) begin
      report_mismatch(" beat with no vector outstanding");
    end else begin
      want = packed_q.pop_front();
      if (got.word_low !== want.word_low)
        diffs = {diffs, $sformatf(" word_low %h exp %h", got.word_low, want.word_low)};
      if (got.word_mid !== want.word_mid)
        diffs = {diffs, $sformatf(" word_mid %h exp %h", got.word_mid, want.word_mid)};
      if (got.word_high !== want.word_high)
        diffs = {diffs, $sformatf(" word_high %h exp %h", got.word_high, want.word_high)};
      if (got.write_valid !== want.write_valid)
        diffs = {diffs, $sformatf(" write_valid %b exp %b", got.write_valid,
                                  want.write_valid)};
      if (got.byte_count !== want.byte_count)
        diffs = {diffs, $sformatf(" byte_count %0d exp %0d", got.byte_count,
                                  want.byte_count)};
      if (diffs != "") report_mismatch(diffs);
    end
  endtask

  // channel monitor: check output first, then queue the new vector
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAW;
      packed_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        check_beat('{word_low: out_i.word_low, word_mid: out_i.word_mid,
                     word_high: out_i.word_high, write_valid: out_i.write_valid,
                     byte_count: out_i.byte_count});
      end
      if (in_i.valid && in_i.ready) begin
        packed_q.push_back(pack_vector(mode_q, in_i.comp_a, in_i.comp_b, in_i.comp_c));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= mode_e'(cfg_i.pack_mode);
      end
    end
  end

endmodule

@@ verif/shared_exponent_vector_encoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_exponent_vector_encoder_top_tb
// Drives the encoder through every pack mode: a short set of edge vectors
// per mode, then random phases with clustered exponents, classification
// boundaries and invalid patterns. Both sides stall at random; one long
// output stall backs the pipeline up. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module shared_exponent_vector_encoder_top_tb;
  import sevec_pkg::*;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned STEADY_PHASE    = 5;    // no idling on either side
  localparam int unsigned IDLE_PCT        = 34;
  localparam int unsigned HOLD_AT_BEAT    = 400;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned NUM_EDGE        = 7;

  // a, b, c
  localparam logic [95:0] EDGE_VECS [NUM_EDGE] = '{
    {32'h0000_0000, 32'h0000_0000, 32'h0000_0000},  // all too small
    {32'hFFFF_FFFF, 32'h7F80_0000, 32'h7F7F_FFFF},  // invalid, invalid at the limit, just below invalid
    {32'h4000_0000, 32'h3FFF_FFFF, 32'h3080_0000},  // big and small thresholds
    {32'h307F_FFFF, 32'h3F80_0000, 32'h3E00_0001},  // just too small, normal
    {32'h3FFF_FFFF, 32'h3000_0000, 32'h0000_0001},  // shift wraps around
    {32'h3000_0000, 32'h2F80_0000, 32'h1234_5678},  // largest too small
    {32'h3F80_0000, 32'h8000_0000, 32'h3E00_0000}   // one negative component
  };
  localparam mode_e EDGE_MODES [4] = '{MODE_RAW, MODE_HALF, MODE_SE32, MODE_SE24};
  localparam mode_e PHASE_MODES [RANDOM_PHASES] = '{
    MODE_SE24, MODE_RAW, MODE_HALF, MODE_SE32, MODE_RAW, MODE_SE24, MODE_HALF, MODE_SE32
  };

  logic        clk;
  logic        rst_n;
  int unsigned vecs_sent = 0;
  int unsigned beats_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;

  sevec_cfg_if cfg_bus ();
  sevec_in_if  vec_bus ();
  sevec_out_if pack_bus ();

  shared_exponent_vector_encoder_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (vec_bus),
    .out_o  (pack_bus)
  );

  sevec_pack_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_i            (cfg_bus),
    .in_i             (vec_bus),
    .out_i            (pack_bus),
    .mismatch_count_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random component: mostly near a shared base exponent, sometimes extreme
  function automatic logic [31:0] rand_comp(logic [7:0] base);
    logic [31:0] w;
    w = {1'b0, base - 8'($urandom_range(4)), 23'($urandom)};
    case ($urandom_range(15))
      0: w = $urandom;
      1: w = $urandom_range(32'hFFFF_FFFF, LIM_WRONG);
      2, 3: w = $urandom_range(LIM_WRONG - 1, LIM_BIG);
      4, 5: w = $urandom_range(LIM_SMALL - 1, 0);
      6: begin
        case ($urandom_range(5))
          0: w = LIM_SMALL;
          1: w = LIM_SMALL - 1;
          2: w = LIM_BIG;
          3: w = LIM_BIG - 1;
          4: w = LIM_WRONG;
          default: w = LIM_WRONG - 1;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // offer one vector, with random idle cycles ahead of it outside the steady phase
  task automatic send_vec(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        vec_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    vec_bus.valid  <= 1'b1;
    vec_bus.comp_a <= a;
    vec_bus.comp_b <= b;
    vec_bus.comp_c <= c;
    do @(posedge clk); while (!vec_bus.ready);
    vecs_sent++;
  endtask

  // wait for the pipeline to empty, then write the pack mode
  task automatic drain_and_set_mode(mode_e m);
    vec_bus.valid <= 1'b0;
    while (beats_taken != vecs_sent) @(posedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.pack_mode <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [7:0] base;
    rst_n             <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.pack_mode <= MODE_RAW;
    vec_bus.valid     <= 1'b0;
    vec_bus.comp_a    <= '0;
    vec_bus.comp_b    <= '0;
    vec_bus.comp_c    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edge vectors in every mode; the first set runs on the reset mode
    for (int m = 0; m < 4; m++) begin
      if (m != 0) drain_and_set_mode(EDGE_MODES[m]);
      for (int i = 0; i < NUM_EDGE; i++) begin
        send_vec(EDGE_VECS[i][95:64], EDGE_VECS[i][63:32], EDGE_VECS[i][31:0]);
      end
    end

    // random phases
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_and_set_mode(PHASE_MODES[p]);
      steady = (p == STEADY_PHASE);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        base = 8'($urandom_range(8'h7F, 8'h50));
        send_vec(rand_comp(base), rand_comp(base), rand_comp(base));
      end
    end
    steady = 1'b0;
    vec_bus.valid <= 1'b0;

    while (beats_taken != vecs_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // output side: random stalls, one long hold once the pipeline is busy
  initial begin
    pack_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pack_bus.valid && pack_bus.ready) beats_taken++;
      if (!hold_done && beats_taken == HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        pack_bus.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        pack_bus.ready <= 1'b1;
      end else begin
        pack_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((vec_bus.valid && vec_bus.ready) || (pack_bus.valid && pack_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
